### hdl/color_pair_warp_macros.svh
// assertion macros used by the color pair warp controller
`ifndef COLOR_PAIR_WARP_MACROS_SVH
`define COLOR_PAIR_WARP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property that must hold in the cycle after its trigger
`define CPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cpw_pkg.sv
// types and constants of the color pair warp block
package cpw_pkg;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [15:0] LN2_Q16 = 16'd45426;
  // ceil(2^36 / ln2_q16), exact quotient for any 20-bit dividend
  localparam logic [20:0] LN2_RECIP = 21'd1512779;

  // quotient bits of each division run
  localparam logic [4:0] QB_RATIO = 5'd17;
  localparam logic [4:0] QB_X     = 5'd20;
  localparam logic [4:0] QB_F     = 5'd17;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] in_l;
    logic signed [15:0] in_a;
    logic signed [15:0] in_b;
    logic signed [15:0] to_l;
    logic signed [15:0] to_a;
    logic signed [15:0] to_b;
    logic [15:0]        pair_weight;
  } cpw_in_t;

  typedef struct packed {
    logic signed [15:0] out_l;
    logic signed [15:0] out_a;
    logic signed [15:0] out_b;
  } cpw_out_t;

  typedef enum logic [4:0] {
    OP_NONE      = 5'd0,
    OP_LATCH     = 5'd1,
    OP_CLEAR     = 5'd2,
    OP_LOAD      = 5'd3,
    OP_READ      = 5'd4,
    OP_DIST_MUL  = 5'd5,
    OP_DIST_ACC  = 5'd6,
    OP_MIN_UPD   = 5'd7,
    OP_HIT       = 5'd8,
    OP_PASS      = 5'd9,
    OP_SUM_DIV   = 5'd10,
    OP_SUM_ACC   = 5'd11,
    OP_X_DIV     = 5'd12,
    OP_N_DIV     = 5'd13,
    OP_EXP_INIT  = 5'd14,
    OP_TERM_MUL  = 5'd15,
    OP_TERM_DIV  = 5'd16,
    OP_TERM_ACC  = 5'd17,
    OP_E_DIV     = 5'd18,
    OP_F_MUL     = 5'd19,
    OP_F_ADD     = 5'd20,
    OP_ROUND     = 5'd21,
    OP_BLEND_MUL = 5'd22,
    OP_BLEND_OUT = 5'd23,
    OP_OUT_LOAD  = 5'd24
  } cpw_op_e;

  typedef struct packed {
    cpw_op_e    op;
    logic [1:0] chan;
    logic [3:0] k;
  } cpw_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       load_skip;
    logic       table_empty;
    logic       last_pair;
    logic       dmin_zero;
    logic       exp_skip;
    logic       n_big;
    logic       div_done;
  } cpw_sts_t;

endpackage

### hdl/cpw_divider.sv
// iterative restoring divider, one quotient bit per cycle
module cpw_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [50:0] dividend_i,
  input  logic [33:0] divisor_i,
  input  logic [4:0]  qbits_i,
  output logic [29:0] quo_o,
  output logic        done_o
);

  logic [50:0] rem_q, rem_d;
  logic [50:0] dv_q, dv_d;
  logic [29:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] dv_wide;

  assign dv_wide = {30'd0, divisor_i} << (qbits_i - 5'd1);

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dv_d   = dv_wide[50:0];
      quo_d  = '0;
      cnt_d  = qbits_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= dv_q) begin
        rem_d = rem_q - dv_q;
        quo_d = {quo_q[28:0], 1'b1};
      end else begin
        quo_d = {quo_q[28:0], 1'b0};
      end
      dv_d  = dv_q >> 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

### hdl/cpw_datapath.sv
// pair table, shared multiplier, divider and accumulators
module cpw_datapath #(
  parameter int PAIR_SLOTS = 8,
  localparam int CNT_W = $clog2(PAIR_SLOTS + 1),
  localparam int IDX_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [16:0]        cfg_data_i,
  input  cpw_pkg::cpw_in_t   in_data_i,
  input  cpw_pkg::cpw_cmd_t  cmd_i,
  input  logic [CNT_W-1:0]   pair_idx_i,
  output cpw_pkg::cpw_sts_t  sts_o,
  output cpw_pkg::cpw_out_t  out_data_o
);
  import cpw_pkg::*;

  localparam int SUM_W  = 17 + CNT_W;
  localparam int ACC_W  = 34 + CNT_W;
  localparam int WARP_W = ACC_W - 15;

  typedef struct packed {
    logic [2:0][15:0] from_c;
    logic [2:0][15:0] to_c;
    logic [15:0]      weight;
  } pair_t;

  pair_t mem [PAIR_SLOTS];
  pair_t rd_q;
  pair_t entry;

  cpw_in_t               in_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [16:0]           amount_q;
  logic [33:0]           dist_q;
  logic [33:0]           dmin_q;
  logic signed [16:0]    best_q [3];
  logic [SUM_W-1:0]      sum_q;
  logic signed [ACC_W-1:0] acc_q [3];
  logic [29:0]           qv_q;
  logic [30:0]           term_q;
  logic signed [31:0]    esum_q;
  logic [4:0]            n_q;
  logic signed [WARP_W-1:0] warp_q [3];
  logic signed [15:0]    res_q [3];
  cpw_out_t              out_q;
  logic signed [65:0]    mul_q;

  logic signed [15:0] px [3];
  logic signed [16:0] diff_pf [3];
  logic signed [16:0] dt [3];
  logic signed [32:0] mul_a, mul_b;
  logic [16:0]        amt;
  logic               black, full;
  logic               div_start, div_done;
  logic [50:0]        div_dividend;
  logic [33:0]        div_divisor;
  logic [4:0]         div_qbits;
  logic [29:0]        div_quo;
  logic [4:0]         n_val;
  logic [20:0]        ln2_mult;
  logic [20:0]        x_red;
  logic [29:0]        term_quo;
  logic [31:0]        esum_pos;
  logic [31:0]        e_val;
  logic signed [65:0] acc_round [3];
  logic signed [65:0] blend_o;
  logic signed [15:0] blend_sat;

  // round to nearest at bit 16, ties away from zero
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r   = (mag + 66'd32768) >> 16;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  // ceil(2^32 / k) for k from 2 to 8 (1 otherwise), exact floor division of any 30-bit value by k
  function automatic logic [31:0] recip_k(input logic [3:0] k);
    logic [31:0] m;
    case (k)
      4'd2:    m = 32'h80000000;
      4'd3:    m = 32'h55555556;
      4'd4:    m = 32'h40000000;
      4'd5:    m = 32'h33333334;
      4'd6:    m = 32'h2aaaaaab;
      4'd7:    m = 32'h24924925;
      4'd8:    m = 32'h20000000;
      default: m = 32'd1;
    endcase
    return m;
  endfunction

  assign px[0] = in_q.in_l;
  assign px[1] = in_q.in_a;
  assign px[2] = in_q.in_b;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign diff_pf[c] = {px[c][15], px[c]} -
                        {rd_q.from_c[c][15], rd_q.from_c[c]};
    assign dt[c] = {rd_q.from_c[c][15], rd_q.from_c[c]} -
                   {rd_q.to_c[c][15], rd_q.to_c[c]};
    assign acc_round[c] = rnd16(66'(acc_q[c]));
  end

  assign entry.from_c = {in_q.in_b, in_q.in_a, in_q.in_l};
  assign entry.to_c   = {in_q.to_b, in_q.to_a, in_q.to_l};
  assign entry.weight = in_q.pair_weight;

  assign black = (in_q.in_l == '0) && (in_q.in_a == '0) && (in_q.in_b == '0) &&
                 (in_q.to_l == '0) && (in_q.to_a == '0) && (in_q.to_b == '0);
  assign full  = (cnt_q == CNT_W'(PAIR_SLOTS));
  assign amt   = amount_q[16] ? 17'h10000 : amount_q;

  // n = x / ln2 from the reciprocal product, r = x - n * ln2
  assign n_val    = mul_q[40:36];
  assign ln2_mult = 21'(n_val) * 21'(LN2_Q16);
  assign x_red    = 21'(div_quo[19:0]) - ln2_mult;

  // series term divided by k from the reciprocal product
  assign term_quo = (cmd_i.k == 4'd1) ? mul_q[29:0] : mul_q[61:32];

  assign esum_pos = esum_q[31] ? 32'd0 : 32'(esum_q);
  assign e_val    = esum_pos >> (5'd14 + n_q);

  assign blend_o   = 66'(px[cmd_i.chan]) - rnd16(mul_q);
  assign blend_sat = (blend_o > 66'sd32767) ? 16'sh7fff :
                     (blend_o < -66'sd32768) ? 16'sh8000 : blend_o[15:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_DIST_MUL: begin
        mul_a = 33'(diff_pf[cmd_i.chan]);
        mul_b = 33'(diff_pf[cmd_i.chan]);
      end
      OP_N_DIV: begin
        mul_a = $signed({13'd0, div_quo[19:0]});
        mul_b = $signed({12'd0, LN2_RECIP});
      end
      OP_TERM_MUL: begin
        mul_a = $signed({2'b00, term_q});
        mul_b = $signed({3'b000, qv_q});
      end
      OP_TERM_DIV: begin
        mul_a = $signed({3'b000, mul_q[59:30]});
        mul_b = $signed({1'b0, recip_k(cmd_i.k)});
      end
      OP_F_MUL: begin
        mul_a = 33'(dt[cmd_i.chan]);
        mul_b = $signed({16'd0, div_quo[16:0]});
      end
      OP_BLEND_MUL: begin
        mul_a = 33'(warp_q[cmd_i.chan]);
        mul_b = $signed({16'd0, amt});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 34'd1;
    div_qbits    = QB_RATIO;
    case (cmd_i.op)
      OP_SUM_DIV: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, dmin_q, 16'd0};
        div_divisor  = dist_q;
        div_qbits    = QB_RATIO;
      end
      OP_X_DIV: begin
        div_start    = 1'b1;
        div_dividend = {9'd0, dist_q, 8'd0};
        div_divisor  = {18'd0, rd_q.weight};
        div_qbits    = QB_X;
      end
      OP_E_DIV: begin
        div_start    = 1'b1;
        div_dividend = {3'd0, e_val, 16'd0};
        div_divisor  = 34'(sum_q);
        div_qbits    = QB_F;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  cpw_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .qbits_i    (div_qbits),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  // pair table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      mem[cnt_q[IDX_W-1:0]] <= entry;
    end
    if (cmd_i.op == OP_READ) begin
      rd_q <= mem[pair_idx_i[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      amount_q <= 17'h10000;
    end else begin
      if (cfg_valid_i) begin
        amount_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_CLEAR) begin
        cnt_q <= '0;
      end else if (cmd_i.op == OP_LOAD) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_LATCH: begin
        in_q  <= in_data_i;
        sum_q <= '0;
        for (int c = 0; c < 3; c++) begin
          acc_q[c] <= '0;
        end
      end
      OP_DIST_ACC: begin
        if (cmd_i.chan == 2'd0) begin
          dist_q <= mul_q[33:0];
        end else begin
          dist_q <= dist_q + mul_q[33:0];
        end
      end
      OP_MIN_UPD: begin
        if (pair_idx_i == '0 || dist_q < dmin_q) begin
          dmin_q <= dist_q;
          for (int c = 0; c < 3; c++) begin
            best_q[c] <= dt[c];
          end
        end
      end
      OP_HIT: begin
        for (int c = 0; c < 3; c++) begin
          warp_q[c] <= WARP_W'(best_q[c]);
        end
      end
      OP_PASS: begin
        for (int c = 0; c < 3; c++) begin
          warp_q[c] <= '0;
        end
      end
      OP_SUM_ACC: begin
        sum_q <= sum_q + SUM_W'(div_quo[16:0]);
      end
      OP_EXP_INIT: begin
        qv_q   <= {x_red[15:0], 14'd0};
        term_q <= 31'h40000000;
        esum_q <= 32'sh40000000;
        n_q    <= n_val;
      end
      OP_TERM_ACC: begin
        term_q <= {1'b0, term_quo};
        if (cmd_i.k[0]) begin
          esum_q <= esum_q - $signed({2'b00, term_quo});
        end else begin
          esum_q <= esum_q + $signed({2'b00, term_quo});
        end
      end
      OP_F_ADD: begin
        acc_q[cmd_i.chan] <= acc_q[cmd_i.chan] + ACC_W'($signed(mul_q[33:0]));
      end
      OP_ROUND: begin
        for (int c = 0; c < 3; c++) begin
          warp_q[c] <= acc_round[c][WARP_W-1:0];
        end
      end
      OP_BLEND_OUT: begin
        res_q[cmd_i.chan] <= blend_sat;
      end
      OP_OUT_LOAD: begin
        out_q.out_l <= res_q[0];
        out_q.out_a <= res_q[1];
        out_q.out_b <= res_q[2];
      end
      default: begin
      end
    endcase
  end

  assign sts_o.req_type    = in_q.req_type;
  assign sts_o.load_skip   = black || full;
  assign sts_o.table_empty = (cnt_q == '0);
  assign sts_o.last_pair   = (pair_idx_i + CNT_W'(1) == cnt_q);
  assign sts_o.dmin_zero   = (dmin_q == '0);
  // weight zero, or d/w so large that the exponential is zero
  assign sts_o.exp_skip    = (rd_q.weight == '0) || (dist_q >= {6'd0, rd_q.weight, 12'd0});
  assign sts_o.n_big       = (n_val > 5'd16);
  assign sts_o.div_done    = div_done;

  assign out_data_o = out_q;

endmodule

### hdl/cpw_ctrl.sv
// sequencer for the color pair warp passes and output handshake
`include "color_pair_warp_macros.svh"

module cpw_ctrl #(
  parameter int PAIR_SLOTS = 8,
  localparam int CNT_W = $clog2(PAIR_SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpw_pkg::cpw_cmd_t cmd_o,
  output logic [CNT_W-1:0]  pair_idx_o,
  input  cpw_pkg::cpw_sts_t sts_i
);
  import cpw_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001,
    S_DECODE  = 22'h000002,
    S_READ    = 22'h000004,
    S_DMUL    = 22'h000008,
    S_DACC    = 22'h000010,
    S_PAIR    = 22'h000020,
    S_HITCHK  = 22'h000040,
    S_DIVWAIT = 22'h000080,
    S_SUMACC  = 22'h000100,
    S_NEXTP   = 22'h000200,
    S_NDIV    = 22'h000400,
    S_NCHK    = 22'h000800,
    S_TMUL    = 22'h001000,
    S_TDIV    = 22'h002000,
    S_TACC    = 22'h004000,
    S_EDIV    = 22'h008000,
    S_FMUL    = 22'h010000,
    S_FADD    = 22'h020000,
    S_ROUND   = 22'h040000,
    S_BMUL    = 22'h080000,
    S_BOUT    = 22'h100000,
    S_FINISH  = 22'h200000
  } state_e;

  typedef enum logic [1:0] {
    PASS_MIN = 2'd0,
    PASS_SUM = 2'd1,
    PASS_EXP = 2'd2
  } pass_e;

  state_e           state_q, state_d;
  state_e           ret_q, ret_d;
  pass_e            pass_q, pass_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [1:0]       c_q, c_d;
  logic [3:0]       k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    pass_d    = pass_q;
    idx_d     = idx_q;
    c_d       = c_q;
    k_d       = k_q;
    cmd_o.op  = OP_NONE;
    cmd_o.chan = c_q;
    cmd_o.k   = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (sts_i.req_type)
          REQ_CLEAR: cmd_o.op = OP_CLEAR;
          REQ_LOAD: begin
            if (!sts_i.load_skip) begin
              cmd_o.op = OP_LOAD;
            end
          end
          REQ_PIXEL: begin
            if (sts_i.table_empty) begin
              cmd_o.op = OP_PASS;
              c_d      = 2'd0;
              state_d  = S_BMUL;
            end else begin
              pass_d  = PASS_MIN;
              idx_d   = '0;
              state_d = S_READ;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_READ: begin
        cmd_o.op = OP_READ;
        c_d      = 2'd0;
        state_d  = S_DMUL;
      end
      S_DMUL: begin
        cmd_o.op = OP_DIST_MUL;
        state_d  = S_DACC;
      end
      S_DACC: begin
        cmd_o.op = OP_DIST_ACC;
        if (c_q == 2'd2) begin
          c_d     = 2'd0;
          state_d = S_PAIR;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = S_DMUL;
        end
      end
      S_PAIR: begin
        case (pass_q)
          PASS_MIN: begin
            cmd_o.op = OP_MIN_UPD;
            if (sts_i.last_pair) begin
              state_d = S_HITCHK;
            end else begin
              idx_d   = idx_q + CNT_W'(1);
              state_d = S_READ;
            end
          end
          PASS_SUM: begin
            cmd_o.op = OP_SUM_DIV;
            ret_d    = S_SUMACC;
            state_d  = S_DIVWAIT;
          end
          PASS_EXP: begin
            if (sts_i.exp_skip) begin
              state_d = S_NEXTP;
            end else begin
              cmd_o.op = OP_X_DIV;
              ret_d    = S_NDIV;
              state_d  = S_DIVWAIT;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_HITCHK: begin
        if (sts_i.dmin_zero) begin
          cmd_o.op = OP_HIT;
          c_d      = 2'd0;
          state_d  = S_BMUL;
        end else begin
          pass_d  = PASS_SUM;
          idx_d   = '0;
          state_d = S_READ;
        end
      end
      S_DIVWAIT: begin
        if (sts_i.div_done) begin
          state_d = ret_q;
        end
      end
      S_SUMACC: begin
        cmd_o.op = OP_SUM_ACC;
        state_d  = S_NEXTP;
      end
      S_NEXTP: begin
        if (sts_i.last_pair) begin
          if (pass_q == PASS_SUM) begin
            pass_d  = PASS_EXP;
            idx_d   = '0;
            state_d = S_READ;
          end else begin
            state_d = S_ROUND;
          end
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_READ;
        end
      end
      S_NDIV: begin
        cmd_o.op = OP_N_DIV;
        state_d  = S_NCHK;
      end
      S_NCHK: begin
        if (sts_i.n_big) begin
          state_d = S_NEXTP;
        end else begin
          cmd_o.op = OP_EXP_INIT;
          k_d      = 4'd1;
          state_d  = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd_o.op = OP_TERM_MUL;
        state_d  = S_TDIV;
      end
      S_TDIV: begin
        cmd_o.op = OP_TERM_DIV;
        state_d  = S_TACC;
      end
      S_TACC: begin
        cmd_o.op = OP_TERM_ACC;
        if (k_q == 4'd8) begin
          state_d = S_EDIV;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = S_TMUL;
        end
      end
      S_EDIV: begin
        cmd_o.op = OP_E_DIV;
        c_d      = 2'd0;
        ret_d    = S_FMUL;
        state_d  = S_DIVWAIT;
      end
      S_FMUL: begin
        cmd_o.op = OP_F_MUL;
        state_d  = S_FADD;
      end
      S_FADD: begin
        cmd_o.op = OP_F_ADD;
        if (c_q == 2'd2) begin
          c_d     = 2'd0;
          state_d = S_NEXTP;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = S_FMUL;
        end
      end
      S_ROUND: begin
        cmd_o.op = OP_ROUND;
        c_d      = 2'd0;
        state_d  = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.op = OP_BLEND_MUL;
        state_d  = S_BOUT;
      end
      S_BOUT: begin
        cmd_o.op = OP_BLEND_OUT;
        if (c_q == 2'd2) begin
          state_d = S_FINISH;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = S_BMUL;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      pass_q      <= PASS_MIN;
      idx_q       <= '0;
      c_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pass_q      <= pass_d;
      idx_q       <= idx_d;
      c_q         <= c_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pair_idx_o  = idx_q;

  `CPW_ASSERT_NEXT(a_accept_decodes, in_valid_i && !in_stall_o, state_q == S_DECODE, "accepted transaction not decoded")
  `CPW_ASSERT_NEXT(a_finish_loads, state_q == S_FINISH && out_free, out_valid_q && state_q == S_IDLE, "finished result not presented")
  `CPW_ASSERT(a_chan_range, c_q != 2'd3, "channel counter out of range")
  `CPW_ASSERT(a_term_range, !(state_q == S_TMUL) || (k_q >= 4'd1 && k_q <= 4'd8), "series term index out of range")

endmodule

### hdl/color_pair_warp.sv
// a pixel with an empty table goes straight to the blend; with N pairs it runs the
// nearest search, plus the ratio pass and the exponential pass unless a pair matches
// exactly, all using the shared one-bit-per-cycle divider and the single multiplier;
// loads and clears are done in the decode step; one transaction is worked at a time
// reset empties the pair table, clears the output valid and sets amount to 65536
// top level of the color pair warp block
module color_pair_warp #(
  parameter int PAIR_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpw_pkg::cpw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpw_pkg::cpw_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [16:0]       cfg_data_i
);
  import cpw_pkg::*;

  localparam int CNT_W = $clog2(PAIR_SLOTS + 1);

  cpw_cmd_t         cmd;
  cpw_sts_t         sts;
  logic [CNT_W-1:0] pair_idx;

  assign cfg_ready_o = 1'b1;

  cpw_ctrl #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .pair_idx_o  (pair_idx),
    .sts_i       (sts)
  );

  cpw_datapath #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .pair_idx_i  (pair_idx),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
